>>> rtl/kctf_pkg.sv
// ----------------------------------------------------------------------------
// kctf_pkg: shared types and constants of the keyed confidence table
// entry record, scan beat, write-back bus, configuration set and codes
// ----------------------------------------------------------------------------
package kctf_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W  = $clog2(ENTRIES + 1);

    // fixed field widths
    localparam int PEER_W  = 32;
    localparam int PROTO_W = 2;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 3;

    // input op codes
    localparam logic OP_FOLD  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // verdict codes (codes 2 and 3 fold as unobserved)
    localparam logic [1:0] VERD_MET      = 2'd0;
    localparam logic [1:0] VERD_VIOLATED = 2'd1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BASELINE  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MET_STEP  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_VIO_STEP  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SAL_STEP  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] BASELINE_RST  = 8'd128;
    localparam logic [CFG_W-1:0] MET_STEP_RST  = 8'd2;
    localparam logic [CFG_W-1:0] VIO_STEP_RST  = 8'd16;
    localparam logic [CFG_W-1:0] SAL_STEP_RST  = 8'd1;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] baseline;
        logic [CFG_W-1:0] met_step;
        logic [CFG_W-1:0] vio_step;
        logic [CFG_W-1:0] sal_step;
        logic [CFG_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  conf;
        logic [15:0] sal;
        logic [15:0] met;
        logic [15:0] vio;
        logic [15:0] unobs;
        logic [7:0]  streak;
        logic [7:0]  longest;
        logic        flag;
    } entry_rec_t;

    // lookup beat walking down the chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        entry_rec_t        rec;
    } token_t;

    // write-back broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [PEER_W-1:0]  peer;
        logic [PROTO_W-1:0] proto;
        entry_rec_t         rec;
    } wr_t;

endpackage

>>> rtl/kctf_cell.sv
// ----------------------------------------------------------------------------
// kctf_cell: one table slot of the lookup chain
// holds key and record of one entry, compares the passing lookup beat
// ----------------------------------------------------------------------------
module kctf_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [kctf_pkg::SLOT_W-1:0]    cell_idx,
    input  logic [kctf_pkg::USED_W-1:0]    used_entries,
    input  logic [kctf_pkg::PEER_W-1:0]    key_peer,
    input  logic [kctf_pkg::PROTO_W-1:0]   key_protocol,
    input  kctf_pkg::token_t               tok_in,
    output kctf_pkg::token_t               tok_out,
    input  kctf_pkg::wr_t                  wr
);
    import kctf_pkg::*;

    logic [PEER_W-1:0]  peer_reg;
    logic [PROTO_W-1:0] proto_reg;
    entry_rec_t         rec_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               active;
    logic               match;

    assign active = (USED_W'(cell_idx) < used_entries);
    assign match  = active && (peer_reg == key_peer) && (proto_reg == key_protocol);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && match)
        begin
            tok_next.hit  = 1'b1;
            tok_next.slot = cell_idx;
            tok_next.rec  = rec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // entry storage, undefined until allocated
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.slot == cell_idx))
        begin
            peer_reg  <= wr.peer;
            proto_reg <= wr.proto;
            rec_reg   <= wr.rec;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/kctf_update.sv
// ----------------------------------------------------------------------------
// kctf_update: verdict fold of one entry record
// saturating counters, confidence step, streak and contradiction flag
// ----------------------------------------------------------------------------
module kctf_update (
    input  kctf_pkg::entry_rec_t rec_in,
    input  logic [1:0]           verdict,
    input  kctf_pkg::cfg_t       cfg,
    output kctf_pkg::entry_rec_t rec_out
);
    import kctf_pkg::*;

    logic [8:0]  conf_sum;
    logic [16:0] sal_sum;
    logic [7:0]  streak_inc;

    assign conf_sum   = {1'b0, rec_in.conf} + {1'b0, cfg.met_step};
    assign sal_sum    = {1'b0, rec_in.sal} + {9'd0, cfg.sal_step};
    assign streak_inc = (rec_in.streak == 8'hFF) ? 8'hFF : rec_in.streak + 8'd1;

    always_comb
    begin
        rec_out = rec_in;
        case (verdict)
            VERD_MET:
            begin
                rec_out.met    = (rec_in.met == 16'hFFFF) ? 16'hFFFF : rec_in.met + 16'd1;
                rec_out.conf   = conf_sum[8] ? 8'hFF : conf_sum[7:0];
                rec_out.streak = 8'd0;
            end
            VERD_VIOLATED:
            begin
                rec_out.vio    = (rec_in.vio == 16'hFFFF) ? 16'hFFFF : rec_in.vio + 16'd1;
                rec_out.conf   = (rec_in.conf > cfg.vio_step) ?
                                 rec_in.conf - cfg.vio_step : 8'd0;
                rec_out.sal    = sal_sum[16] ? 16'hFFFF : sal_sum[15:0];
                rec_out.streak = streak_inc;
                if (streak_inc > rec_in.longest)
                begin
                    rec_out.longest = streak_inc;
                end
                if (streak_inc >= cfg.threshold)
                begin
                    rec_out.flag = 1'b1;
                end
            end
            default:
            begin
                rec_out.unobs = (rec_in.unobs == 16'hFFFF) ? 16'hFFFF :
                                rec_in.unobs + 16'd1;
            end
        endcase
    end

endmodule

>>> rtl/keyed_confidence_table_fold.sv
// ----------------------------------------------------------------------------
// keyed_confidence_table_fold: keyed belief table with verdict folding
// chain of slot cells for lookup, one fold unit, registered result beat
// ----------------------------------------------------------------------------
// A fold beat passes from acceptance through the launch register, then through
// one register per table slot (ENTRIES, here 16) while it walks the chain of
// slot cells, and then through the finish state, which folds the verdict, writes
// the entry back and loads the result register. A clear beat goes straight to
// the finish state. The block handles one item at a time; the next item is
// taken as soon as the previous result sits in the output register, and the
// finish state waits only while that register still holds an untaken result. No
// clearing pass follows reset: slots past the used count are never compared.
module keyed_confidence_table_fold (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [kctf_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [kctf_pkg::CFG_W-1:0]   cfg_wdata,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [31:0]                  peer_id,
    input  logic [1:0]                   protocol,
    input  logic [1:0]                   verdict,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         accepted,
    output logic [3:0]                   slot,
    output logic [7:0]                   confidence,
    output logic [15:0]                  salience,
    output logic [15:0]                  met_count,
    output logic [15:0]                  violated_count,
    output logic [15:0]                  unobserved_count,
    output logic [7:0]                   streak,
    output logic [7:0]                   longest_streak,
    output logic                         contradiction,
    output logic [15:0]                  drop_count,
    output logic [4:0]                   entries_used
);
    import kctf_pkg::*;

    // configuration registers
    cfg_t               cfg_reg;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [USED_W-1:0]  used_reg;
    logic [USED_W-1:0]  used_next;
    logic [15:0]        drop_reg;
    logic [15:0]        drop_next;
    logic               inject_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    // latched item and lookup outcome
    logic               op_reg;
    logic [PEER_W-1:0]  peer_reg;
    logic [PROTO_W-1:0] proto_reg;
    logic [1:0]         verdict_reg;
    token_t             tok_reg;

    // result payload registers
    logic               res_acc_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    entry_rec_t         res_rec_reg;
    logic [15:0]        res_drop_reg;
    logic [USED_W-1:0]  res_used_reg;
    logic               res_acc_next;
    logic [SLOT_W-1:0]  res_slot_next;
    entry_rec_t         res_rec_next;

    // datapath nets
    token_t             chain [ENTRIES+1];
    wr_t                wr;
    entry_rec_t         fold_src;
    entry_rec_t         fold_rec;
    entry_rec_t         base_rec;
    logic               in_fire;
    logic               out_free;
    logic               finish_go;
    logic               table_full;
    logic [SLOT_W+3:0]  slot_wide;
    logic [USED_W+4:0]  used_wide;

    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign finish_go  = (state_reg == ST_FINISH) && out_free;
    assign table_full = (used_reg >= USED_W'(ENTRIES));

    // configuration decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline  <= BASELINE_RST;
            cfg_reg.met_step  <= MET_STEP_RST;
            cfg_reg.vio_step  <= VIO_STEP_RST;
            cfg_reg.sal_step  <= SAL_STEP_RST;
            cfg_reg.threshold <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASELINE:  cfg_reg.baseline  <= cfg_wdata;
                CFG_MET_STEP:  cfg_reg.met_step  <= cfg_wdata;
                CFG_VIO_STEP:  cfg_reg.vio_step  <= cfg_wdata;
                CFG_SAL_STEP:  cfg_reg.sal_step  <= cfg_wdata;
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // lookup beat enters the chain the cycle after a fold is accepted
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = inject_reg;
    end

    // chain of slot cells, one slot compared per cycle
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kctf_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_idx     (SLOT_W'(i)),
            .used_entries (used_reg),
            .key_peer     (peer_reg),
            .key_protocol (proto_reg),
            .tok_in       (chain[i]),
            .tok_out      (chain[i+1]),
            .wr           (wr)
        );
    end

    // fresh entry for an allocated slot
    always_comb
    begin
        base_rec      = '0;
        base_rec.conf = cfg_reg.baseline;
    end

    assign fold_src = tok_reg.hit ? tok_reg.rec : base_rec;

    kctf_update u_update (
        .rec_in  (fold_src),
        .verdict (verdict_reg),
        .cfg     (cfg_reg),
        .rec_out (fold_rec)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (op == OP_CLEAR) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[ENTRIES].valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, write-back, table counters, result
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        used_next      = used_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_acc_next   = 1'b0;
        res_slot_next  = '0;
        res_rec_next   = '0;
        wr             = '0;
        wr.peer        = peer_reg;
        wr.proto       = proto_reg;
        wr.rec         = fold_rec;
        if (finish_go)
        begin
            out_valid_next = 1'b1;
            if (op_reg == OP_CLEAR)
            begin
                used_next = '0;
                drop_next = '0;
            end
            else if (tok_reg.hit)
            begin
                wr.en         = 1'b1;
                wr.slot       = tok_reg.slot;
                res_acc_next  = 1'b1;
                res_slot_next = tok_reg.slot;
                res_rec_next  = fold_rec;
            end
            else if (!table_full)
            begin
                // new key takes the next free slot
                wr.en         = 1'b1;
                wr.slot       = used_reg[SLOT_W-1:0];
                res_acc_next  = 1'b1;
                res_slot_next = used_reg[SLOT_W-1:0];
                res_rec_next  = fold_rec;
                used_next     = used_reg + USED_W'(1);
            end
            else
            begin
                // table full, fold dropped
                drop_next = (drop_reg == 16'hFFFF) ? 16'hFFFF : drop_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            drop_reg      <= '0;
            inject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            drop_reg      <= drop_next;
            inject_reg    <= in_fire && (op == OP_FOLD);
            out_valid_reg <= out_valid_next;
        end
    end

    // item and lookup latches
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op;
            peer_reg    <= peer_id;
            proto_reg   <= protocol;
            verdict_reg <= verdict;
        end
        if ((state_reg == ST_SCAN) && chain[ENTRIES].valid)
        begin
            tok_reg <= chain[ENTRIES];
        end
        if (finish_go)
        begin
            res_acc_reg  <= res_acc_next;
            res_slot_reg <= res_slot_next;
            res_rec_reg  <= res_rec_next;
            res_drop_reg <= drop_next;
            res_used_reg <= used_next;
        end
    end

    // report slot and used count at their port widths
    assign slot_wide = {4'd0, res_slot_reg};
    assign used_wide = {5'd0, res_used_reg};

    assign out_valid        = out_valid_reg;
    assign accepted         = res_acc_reg;
    assign slot             = slot_wide[3:0];
    assign confidence       = res_rec_reg.conf;
    assign salience         = res_rec_reg.sal;
    assign met_count        = res_rec_reg.met;
    assign violated_count   = res_rec_reg.vio;
    assign unobserved_count = res_rec_reg.unobs;
    assign streak           = res_rec_reg.streak;
    assign longest_streak   = res_rec_reg.longest;
    assign contradiction    = res_rec_reg.flag;
    assign drop_count       = res_drop_reg;
    assign entries_used     = used_wide[4:0];

`ifndef SYNTH
    // used count never passes the table depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(ENTRIES))
        else $error("used count beyond table depth");

    // lookup beat only leaves the chain while the sequencer scans
    a_chain_out_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES].valid |-> (state_reg == ST_SCAN))
        else $error("lookup beat outside scan");

    // write-back only in the fold cycle with room for the result
    a_wr_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> finish_go)
        else $error("write-back outside fold cycle");

    // an accepted fold launches exactly one lookup beat
    a_inject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == OP_FOLD)) |=> (inject_reg && (state_reg == ST_SCAN)))
        else $error("fold accepted without lookup launch");

    // a finished fold leaves a result beat waiting
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> out_valid_reg)
        else $error("fold finished without result beat");
`endif

endmodule
